FILE: hdl/ipv6nd_pkg.sv
// ----------------------------------------------------------------------------
// ipv6nd_pkg
// Shared types and constants of the IPv6 frame classifier and ND responder.
// ----------------------------------------------------------------------------
package ipv6nd_pkg;

    localparam int OUT_BYTES  = 8;
    localparam int HEAD_DEPTH = 78;
    localparam int HEAD_AW    = 7;
    localparam int IDX_W      = 13;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    localparam logic [IDX_W-1:0] IDX_MAX = 13'd8191;
    localparam logic [47:0] ROUTER_MAC_RST = 48'h000123456789;

    localparam logic [7:0] ETH_TYPE_HI = 8'h86;
    localparam logic [7:0] ETH_TYPE_LO = 8'hdd;
    localparam logic [7:0] NH_ICMP6    = 8'd58;
    localparam logic [7:0] HOP_ND      = 8'd255;
    localparam logic [7:0] ICMP_RS     = 8'd133;
    localparam logic [7:0] ICMP_NS     = 8'd135;
    localparam logic [7:0] ICMP_NA     = 8'd136;
    localparam logic [7:0] OPT_TLLA    = 8'd2;

    localparam logic [1:0] DEST_TUNNEL = 2'd0;
    localparam logic [1:0] DEST_REPLY  = 2'd1;
    localparam logic [1:0] DEST_RUNT   = 2'd2;

    // Commands from the classifier to the packer.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_PUT   = 3'd1;
    localparam logic [2:0] OP_FLUSH = 3'd2;
    localparam logic [2:0] OP_REPLY = 3'd3;
    localparam logic [2:0] OP_RUNT  = 3'd4;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  dest;
        logic [63:0] out_data;
        logic [3:0]  byte_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         data;
        logic [HEAD_AW-1:0] upto;
        logic               fin;
    } t_cmd;

    typedef struct packed {
        logic               we;
        logic [HEAD_AW-1:0] addr;
        logic [7:0]         data;
    } t_head_wr;

endpackage

FILE: hdl/ipv6nd_front.sv
// ----------------------------------------------------------------------------
// ipv6nd_front
// Accepts frame bytes, tracks the frame position and class, and issues one
// packer command per byte where one is needed.
// ----------------------------------------------------------------------------
module ipv6nd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipv6nd_pkg::t_in_item i_in,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_q_full,
    input  logic                 i_head_done,
    output logic                 o_cmd_push,
    output ipv6nd_pkg::t_cmd     o_cmd,
    output ipv6nd_pkg::t_head_wr o_head_wr
);
    import ipv6nd_pkg::*;

    localparam logic [1:0] CL_UND  = 2'd0;
    localparam logic [1:0] CL_PEND = 2'd1;
    localparam logic [1:0] CL_TUN  = 2'd2;
    localparam logic [1:0] CL_DROP = 2'd3;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_class, n_class;
    logic [7:0]       r_b12, r_b20;
    logic             r_hop, r_zero, r_lock;
    logic             acc;
    logic [7:0]       b;
    t_cmd             cmd;

    assign b    = i_in.frame_byte;
    assign full = i_q_full || r_lock;
    assign acc  = push && !full;

    always_comb begin
        n_class  = r_class;
        cmd      = '0;
        cmd.op   = OP_NONE;
        cmd.data = b;
        if (r_class == CL_TUN) begin
            cmd.op = OP_PUT;
        end else if (r_class == CL_UND) begin
            if (r_idx == 13'd13) begin
                if (r_b12 != ETH_TYPE_HI || b != ETH_TYPE_LO) begin
                    n_class = CL_DROP;
                end
            end else if (r_idx == 13'd54) begin
                if (r_hop && b == ICMP_RS) begin
                    n_class = CL_DROP;
                end else if (r_hop && b == ICMP_NS) begin
                    n_class = r_zero ? CL_DROP : CL_PEND;
                end else begin
                    n_class  = CL_TUN;
                    cmd.op   = OP_FLUSH;
                    cmd.upto = r_idx[HEAD_AW-1:0];
                end
            end
        end else if (r_class == CL_PEND && r_idx == 13'(HEAD_DEPTH - 1)) begin
            cmd.op  = OP_REPLY;
            n_class = CL_DROP;
        end
        if (i_in.frame_end) begin
            if (r_idx < 13'd13) begin
                cmd.op = OP_RUNT;
            end else if (n_class == CL_UND || n_class == CL_PEND) begin
                // Undecided or unanswered frames go to the tunnel whole.
                cmd.op   = OP_FLUSH;
                cmd.upto = r_idx[HEAD_AW-1:0];
                cmd.fin  = 1'b1;
            end else if (n_class == CL_TUN) begin
                cmd.fin = 1'b1;
            end
        end
        if (i_in.frame_end) begin
            n_idx   = '0;
            n_class = CL_UND;
        end else if (r_idx < IDX_MAX) begin
            n_idx = r_idx + 13'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = acc && cmd.op != OP_NONE;

    assign o_head_wr.we   = acc && r_idx < 13'(HEAD_DEPTH);
    assign o_head_wr.addr = r_idx[HEAD_AW-1:0];
    assign o_head_wr.data = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_class <= CL_UND;
            r_lock  <= 1'b0;
        end else begin
            if (acc) begin
                r_idx   <= n_idx;
                r_class <= n_class;
            end
            // The packer reads the head store for flushes and replies.
            if (o_cmd_push && (cmd.op == OP_FLUSH || cmd.op == OP_REPLY)) begin
                r_lock <= 1'b1;
            end else if (i_head_done) begin
                r_lock <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (r_idx == 13'd12) r_b12 <= b;
            if (r_idx == 13'd20) r_b20 <= b;
            if (r_idx == 13'd21) r_hop <= (r_b20 == NH_ICMP6) && (b == HOP_ND);
            if (r_idx == 13'd22) r_zero <= (b == 8'd0);
            else if (r_idx > 13'd22 && r_idx < 13'd38) r_zero <= r_zero && (b == 8'd0);
        end
    end

endmodule

FILE: hdl/ipv6nd_cmdq.sv
// ----------------------------------------------------------------------------
// ipv6nd_cmdq
// Short command queue between the classifier and the packer.
// ----------------------------------------------------------------------------
module ipv6nd_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ipv6nd_pkg::t_cmd i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ipv6nd_pkg::t_cmd o_cmd
);
    import ipv6nd_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp, r_rp;
    logic [CMDQ_AW:0]   r_cnt;
    logic               wr, rd;

    assign o_full  = r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

endmodule

FILE: hdl/ipv6nd_back.sv
// ----------------------------------------------------------------------------
// ipv6nd_back
// Carries out packer commands: packs bytes into result words, flushes the
// stored header, and builds the neighbor advertisement with its checksum.
// ----------------------------------------------------------------------------
module ipv6nd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [47:0]           i_cfg_data,
    input  ipv6nd_pkg::t_head_wr  i_head_wr,
    input  logic                  i_q_empty,
    input  ipv6nd_pkg::t_cmd      i_cmd,
    output logic                  o_q_pop,
    output logic                  o_head_done,
    output logic                  empty,
    input  logic                  pop,
    output ipv6nd_pkg::t_out_item o_out
);
    import ipv6nd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PUT    = 4'd1;
    localparam logic [3:0] S_FL_RD  = 4'd2;
    localparam logic [3:0] S_FL_WR  = 4'd3;
    localparam logic [3:0] S_FIN    = 4'd4;
    localparam logic [3:0] S_RUNT   = 4'd5;
    localparam logic [3:0] S_SUM_RD = 4'd6;
    localparam logic [3:0] S_SUM_AC = 4'd7;
    localparam logic [3:0] S_RP_RD  = 4'd8;
    localparam logic [3:0] S_RP_WR  = 4'd9;

    typedef struct packed {
        logic               is_mem;
        logic               is_csum;
        logic [HEAD_AW-1:0] addr;
        logic [7:0]         cval;
    } t_rsrc;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] j);
        logic [7:0] v;
        case (j)
            3'd0:    v = mac[47:40];
            3'd1:    v = mac[39:32];
            3'd2:    v = mac[31:24];
            3'd3:    v = mac[23:16];
            3'd4:    v = mac[15:8];
            default: v = mac[7:0];
        endcase
        return v;
    endfunction

    // Where byte k of the advertisement comes from.
    function automatic t_rsrc reply_src(input logic [6:0] k, input logic [47:0] mac);
        t_rsrc s;
        s = '0;
        if (k < 7'd6) begin
            s.is_mem = 1'b1; s.addr = 7'(k + 7'd6);
        end else if (k < 7'd12) begin
            s.cval = mac_byte(mac, 3'(k - 7'd6));
        end else if (k < 7'd18) begin
            s.is_mem = 1'b1; s.addr = k;
        end else if (k == 7'd18) begin
            s.cval = 8'd0;
        end else if (k == 7'd19) begin
            s.cval = 8'd32;
        end else if (k < 7'd22) begin
            s.is_mem = 1'b1; s.addr = k;
        end else if (k < 7'd38) begin
            s.is_mem = 1'b1; s.addr = 7'(k + 7'd40);
        end else if (k < 7'd54) begin
            s.is_mem = 1'b1; s.addr = 7'(k - 7'd16);
        end else if (k == 7'd54) begin
            s.cval = ICMP_NA;
        end else if (k == 7'd55) begin
            s.cval = 8'd0;
        end else if (k < 7'd58) begin
            s.is_csum = 1'b1;
        end else if (k < 7'd78) begin
            s.is_mem = 1'b1; s.addr = k;
        end else if (k == 7'd78) begin
            s.cval = OPT_TLLA;
        end else if (k == 7'd79) begin
            s.cval = 8'd1;
        end else begin
            s.cval = mac_byte(mac, 3'(k - 7'd80));
        end
        return s;
    endfunction

    logic [7:0]         r_mem [HEAD_DEPTH];
    logic [7:0]         r_rdata;
    logic [47:0]        r_mac;
    logic [3:0]         r_st, n_st;
    t_cmd               r_cmd;
    logic [1:0]         r_dest;
    logic [HEAD_AW-1:0] r_i;
    logic [6:0]         r_k;
    logic [23:0]        r_acc;
    logic [63:0]        r_word;
    logic [3:0]         r_cnt;
    logic               r_out_valid;
    t_out_item          r_out;

    t_rsrc              src;
    logic [HEAD_AW-1:0] rd_addr;
    logic [23:0]        f1, f2;
    logic [15:0]        csum;
    logic [7:0]         rbyte;
    logic               can_emit, put_ok, do_put, do_fin, do_runt;
    logic [7:0]         put_b;

    assign src      = reply_src(r_k, r_mac);
    assign rd_addr  = (r_st == S_FL_RD || r_st == S_FL_WR) ? r_i : src.addr;
    assign f1       = {8'd0, r_acc[15:0]} + {16'd0, r_acc[23:16]};
    assign f2       = {8'd0, f1[15:0]} + {16'd0, f1[23:16]};
    assign csum     = ~f2[15:0];
    assign can_emit = !r_out_valid || pop;
    assign put_ok   = (r_cnt != 4'(OUT_BYTES)) || can_emit;
    assign empty    = !r_out_valid;
    assign o_out    = r_out;

    always_comb begin
        if (src.is_mem)       rbyte = r_rdata;
        else if (src.is_csum) rbyte = (r_k[0] == 1'b0) ? csum[15:8] : csum[7:0];
        else                  rbyte = src.cval;
    end

    always_comb begin
        n_st        = r_st;
        o_q_pop     = 1'b0;
        o_head_done = 1'b0;
        do_put      = 1'b0;
        do_fin      = 1'b0;
        do_runt     = 1'b0;
        put_b       = r_cmd.data;
        unique case (r_st)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    case (i_cmd.op)
                        OP_PUT:   n_st = S_PUT;
                        OP_FLUSH: n_st = (i_cmd.upto < 7'd14) ? S_FIN : S_FL_RD;
                        OP_REPLY: n_st = S_SUM_RD;
                        OP_RUNT:  n_st = S_RUNT;
                        default:  n_st = S_IDLE;
                    endcase
                end
            end
            S_PUT: begin
                if (put_ok) begin
                    do_put = 1'b1;
                    n_st   = r_cmd.fin ? S_FIN : S_IDLE;
                end
            end
            S_FL_RD: n_st = S_FL_WR;
            S_FL_WR: begin
                put_b = r_rdata;
                if (put_ok) begin
                    do_put = 1'b1;
                    if (r_i == r_cmd.upto) begin
                        if (r_cmd.fin) begin
                            n_st = S_FIN;
                        end else begin
                            n_st        = S_IDLE;
                            o_head_done = 1'b1;
                        end
                    end else begin
                        n_st = S_FL_RD;
                    end
                end
            end
            S_FIN: begin
                if (can_emit) begin
                    do_fin      = 1'b1;
                    n_st        = S_IDLE;
                    o_head_done = (r_cmd.op == OP_FLUSH) || (r_cmd.op == OP_REPLY);
                end
            end
            S_RUNT: begin
                if (can_emit) begin
                    do_runt = 1'b1;
                    n_st    = S_IDLE;
                end
            end
            S_SUM_RD: n_st = S_SUM_AC;
            S_SUM_AC: n_st = (r_k == 7'd85) ? S_RP_RD : S_SUM_RD;
            S_RP_RD:  n_st = S_RP_WR;
            S_RP_WR: begin
                put_b = rbyte;
                if (put_ok) begin
                    do_put = 1'b1;
                    n_st   = (r_k == 7'd85) ? S_FIN : S_RP_RD;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_mac       <= ROUTER_MAC_RST;
            r_word      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) r_mac <= i_cfg_data;

            if (do_fin || do_runt || (do_put && r_cnt == 4'(OUT_BYTES))) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end

            if (do_put) begin
                if (r_cnt == 4'(OUT_BYTES)) begin
                    r_word <= {56'd0, put_b};
                    r_cnt  <= 4'd1;
                end else begin
                    r_word <= r_word | ({56'd0, put_b} << {r_cnt, 3'b000});
                    r_cnt  <= r_cnt + 4'd1;
                end
            end else if (do_fin) begin
                r_word <= '0;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_head_wr.we) r_mem[i_head_wr.addr] <= i_head_wr.data;
        r_rdata <= r_mem[rd_addr];

        if (do_runt) begin
            r_out.dest       <= DEST_RUNT;
            r_out.out_data   <= '0;
            r_out.byte_count <= '0;
            r_out.last       <= 1'b1;
        end else if (do_fin || (do_put && r_cnt == 4'(OUT_BYTES))) begin
            r_out.dest       <= r_dest;
            r_out.out_data   <= r_word;
            r_out.byte_count <= r_cnt;
            r_out.last       <= do_fin;
        end

        if (r_st == S_IDLE && o_q_pop) begin
            r_cmd  <= i_cmd;
            r_dest <= (i_cmd.op == OP_REPLY) ? DEST_REPLY : DEST_TUNNEL;
            r_i    <= 7'd14;
            r_k    <= 7'd20;
            r_acc  <= 24'd32;
        end
        if (r_st == S_FL_WR && do_put) r_i <= r_i + 7'd1;
        if (r_st == S_SUM_AC) begin
            // Pseudo-header adds only byte 20; byte 21 is skipped.
            if (r_k == 7'd20)           r_acc <= r_acc + {16'd0, rbyte};
            else if (r_k == 7'd21)      r_acc <= r_acc;
            else if (src.is_csum)       r_acc <= r_acc;
            else if (r_k[0] == 1'b0)    r_acc <= r_acc + {8'd0, rbyte, 8'd0};
            else                        r_acc <= r_acc + {16'd0, rbyte};
            r_k <= (r_k == 7'd85) ? 7'd0 : r_k + 7'd1;
        end
        if (r_st == S_RP_WR && do_put) r_k <= r_k + 7'd1;
    end

endmodule

FILE: hdl/ipv6_frame_classify_nd_responder_top.sv
// ----------------------------------------------------------------------------
// ipv6_frame_classify_nd_responder_top
// Classifies Ethernet frame bytes, forwards IPv6 payloads to the tunnel and
// answers neighbor solicitations with a neighbor advertisement.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// input     in         push / full        i_in  (frame_byte, frame_end)
// result    out        empty / pop        o_out (dest, out_data, byte_count, last)
// config    in         i_cfg_valid/ready  i_cfg_data (router_mac)
//
// Frame bytes are taken one per cycle until the four-entry command queue
// fills or a flush or reply locks the head store; the packer takes each
// tunnel byte through its idle and put states, so a long tunnel frame
// settles at the packer's pace. Flushing the stored header reads and then
// writes out each byte, and a reply makes a checksum pass and an output
// pass over the head store, during which full stays high.
// Reset is synchronous and needs no clearing pass. Either side may stall.
// ----------------------------------------------------------------------------
module ipv6_frame_classify_nd_responder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipv6nd_pkg::t_in_item  i_in,
    input  logic                  push,
    output logic                  full,
    output ipv6nd_pkg::t_out_item o_out,
    output logic                  empty,
    input  logic                  pop,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [47:0]           i_cfg_data
);
    import ipv6nd_pkg::*;

    t_cmd     cmd_in, cmd_out;
    t_head_wr head_wr;
    logic     cmd_push, q_full, q_empty, q_pop, head_done;

    assign o_cfg_ready = 1'b1;

    ipv6nd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .push        (push),
        .full        (full),
        .i_q_full    (q_full),
        .i_head_done (head_done),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .o_head_wr   (head_wr)
    );

    ipv6nd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (cmd_out)
    );

    ipv6nd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_head_wr   (head_wr),
        .i_q_empty   (q_empty),
        .i_cmd       (cmd_out),
        .o_q_pop     (q_pop),
        .o_head_done (head_done),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule

FILE: tb/tb_ipv6nd_checker.sv
// ----------------------------------------------------------------------------
// tb_ipv6nd_checker
// Watches the frame and result channels of the IPv6 classifier, predicts the
// results of every accepted frame byte and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ipv6nd_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipv6nd_pkg::t_in_item  i_in,
    input  logic                  i_push,
    input  logic                  i_full,
    input  ipv6nd_pkg::t_out_item i_out,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [47:0]           i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);
    import ipv6nd_pkg::*;

    typedef enum logic [1:0] {
        FC_UNDECIDED, FC_PENDING_NS, FC_TUNNEL, FC_DROP
    } t_frame_class;

    logic [47:0]  mac_reg;
    logic [7:0]   head_bytes [HEAD_DEPTH];
    int unsigned  pos;
    t_frame_class fclass;
    logic [63:0]  word_acc;
    int unsigned  word_fill;
    t_out_item    result_q [$];

    assign o_pending = result_q.size();

    function automatic void push_result(logic [1:0] d, logic [63:0] w, int unsigned c,
                                        logic l);
        t_out_item r;
        r.dest = d;
        r.out_data = w;
        r.byte_count = c[3:0];
        r.last = l;
        result_q.push_back(r);
    endfunction

    function automatic void pack_byte(logic [1:0] d, logic [7:0] v);
        if (word_fill >= OUT_BYTES) begin
            push_result(d, word_acc, word_fill, 1'b0);
            word_acc = '0;
            word_fill = 0;
        end
        word_acc[8*word_fill +: 8] = v;
        word_fill++;
    endfunction

    function automatic void close_packet(logic [1:0] d);
        push_result(d, word_acc, word_fill, 1'b1);
        word_acc = '0;
        word_fill = 0;
    endfunction

    function automatic void flush_stored(int unsigned upto);
        for (int unsigned i = 14; i <= upto && i < HEAD_DEPTH; i++)
            pack_byte(DEST_TUNNEL, head_bytes[i]);
    endfunction

    function automatic void build_advert();
        logic [7:0] r [86];
        logic [31:0] sum;
        for (int i = 0; i < 6; i++) begin
            r[i] = head_bytes[6+i];
            r[6+i] = mac_reg[8*(5-i) +: 8];
            r[80+i] = mac_reg[8*(5-i) +: 8];
            r[12+i] = head_bytes[12+i];
        end
        r[18] = 8'd0;
        r[19] = 8'd32;
        r[20] = head_bytes[20];
        r[21] = head_bytes[21];
        for (int i = 0; i < 16; i++) begin
            r[22+i] = head_bytes[62+i];
            r[38+i] = head_bytes[22+i];
        end
        r[54] = ICMP_NA;
        r[55] = 8'd0;
        r[56] = 8'd0;
        r[57] = 8'd0;
        for (int i = 0; i < 20; i++)
            r[58+i] = head_bytes[58+i];
        r[78] = OPT_TLLA;
        r[79] = 8'd1;
        sum = 32 + r[20];
        for (int i = 22; i < 86; i += 2)
            sum += {r[i], r[i+1]};
        while (sum > 32'hffff)
            sum = (sum & 32'hffff) + (sum >> 16);
        sum = ~sum & 32'hffff;
        r[56] = sum[15:8];
        r[57] = sum[7:0];
        word_acc = '0;
        word_fill = 0;
        for (int i = 0; i < 86; i++)
            pack_byte(DEST_REPLY, r[i]);
        close_packet(DEST_REPLY);
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic fin);
        int unsigned idx;
        logic icmp_hop;
        logic zero_src;
        idx = pos;
        if (idx < HEAD_DEPTH)
            head_bytes[idx] = b;
        if (fclass == FC_TUNNEL) begin
            pack_byte(DEST_TUNNEL, b);
        end else if (fclass == FC_UNDECIDED) begin
            if (idx == 13) begin
                if (head_bytes[12] != ETH_TYPE_HI || head_bytes[13] != ETH_TYPE_LO)
                    fclass = FC_DROP;
            end else if (idx == 54) begin
                icmp_hop = head_bytes[20] == NH_ICMP6 && head_bytes[21] == HOP_ND;
                if (icmp_hop && b == ICMP_RS) begin
                    fclass = FC_DROP;
                end else if (icmp_hop && b == ICMP_NS) begin
                    zero_src = 1'b1;
                    for (int i = 22; i < 38; i++)
                        if (head_bytes[i] != 0)
                            zero_src = 1'b0;
                    fclass = zero_src ? FC_DROP : FC_PENDING_NS;
                end else begin
                    fclass = FC_TUNNEL;
                    word_acc = '0;
                    word_fill = 0;
                    flush_stored(idx);
                end
            end
        end else if (fclass == FC_PENDING_NS && idx == HEAD_DEPTH - 1) begin
            build_advert();
            fclass = FC_DROP;
        end
        if (fin) begin
            if (idx < 13) begin
                push_result(DEST_RUNT, '0, 0, 1'b1);
            end else if (fclass == FC_UNDECIDED || fclass == FC_PENDING_NS) begin
                word_acc = '0;
                word_fill = 0;
                flush_stored(idx);
                close_packet(DEST_TUNNEL);
            end else if (fclass == FC_TUNNEL) begin
                close_packet(DEST_TUNNEL);
            end
            pos = 0;
            fclass = FC_UNDECIDED;
            word_acc = '0;
            word_fill = 0;
        end else if (pos < IDX_MAX) begin
            pos++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mac_reg = ROUTER_MAC_RST;
            pos = 0;
            fclass = FC_UNDECIDED;
            word_acc = '0;
            word_fill = 0;
            o_errors <= 0;
            o_results <= 0;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                mac_reg = i_cfg_data;
            if (i_push && !i_full)
                predict_byte(i_in.frame_byte, i_in.frame_end);
            if (i_pop && !i_empty) begin
                o_results <= o_results + 1;
                if (result_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result %p", $realtime, i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want !== i_out) begin
                        if (o_errors < 10)
                            $display("%0t: result mismatch, expected %p, got %p",
                                     $realtime, want, i_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_ipv6_frame_classify_nd_responder_top.sv
// ----------------------------------------------------------------------------
// tb_ipv6_frame_classify_nd_responder_top
// Drives Ethernet frames into the classifier, changes the router MAC once
// and hands the checking to a separate monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ipv6_frame_classify_nd_responder_top;
    import ipv6nd_pkg::*;

    typedef enum int {
        FK_RUNT, FK_NON_IP, FK_VLAN, FK_TUNNEL, FK_SHORT_IP, FK_RS, FK_NS, FK_DAD,
        FK_SHORT_NS, FK_NOISE
    } t_frame_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    t_in_item    in_item = '0;
    logic        push = 1'b0;
    logic        full;
    t_out_item   out_item;
    logic        empty;
    logic        pop = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [47:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          results;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    bit          steady = 1'b0;
    bit          hold_sink = 1'b0;
    bit          hold_done = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ipv6_frame_classify_nd_responder_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_item), .push(push), .full(full),
        .o_out(out_item), .empty(empty), .pop(pop), .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    tb_ipv6nd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_item), .i_push(push), .i_full(full),
        .i_out(out_item), .i_empty(empty), .i_pop(pop), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data), .o_errors(errors),
        .o_pending(pending), .o_results(results)
    );

    // Result side: random pops, one long hold-off once the run is under way.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= !hold_sink && (steady || $urandom_range(99) >= 37);
        end
    end

    initial begin
        wait (frames_sent >= 2);
        @(posedge clk);
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
        hold_done = 1'b1;
    end

    // The item stays offered after acceptance until the next one replaces it,
    // so push is only lowered by idling or by the caller.
    task automatic send_byte(logic [7:0] b, logic fin);
        while (!steady && $urandom_range(99) < 37) begin
            push <= 1'b0;
            @(posedge clk);
        end
        in_item <= '{frame_byte: b, frame_end: fin};
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(t_frame_kind kind);
        logic [7:0] f [$];
        int len;
        f.delete();
        case (kind)
            FK_RUNT: len = $urandom_range(13, 1);
            FK_SHORT_IP: len = $urandom_range(54, 14);
            FK_SHORT_NS: len = $urandom_range(77, 55);
            FK_NOISE: len = $urandom_range(40, 1);
            FK_NON_IP, FK_VLAN: len = $urandom_range(24, 14);
            FK_RS, FK_DAD: len = $urandom_range(60, 55);
            FK_TUNNEL: len = ($urandom_range(3) == 0) ? $urandom_range(80, 14)
                                                      : $urandom_range(70, 55);
            default: len = $urandom_range(82, 78);
        endcase
        for (int i = 0; i < len; i++)
            f.push_back($urandom_range(255));
        if (kind != FK_NOISE && kind != FK_RUNT && len > 13) begin
            f[12] = ETH_TYPE_HI;
            f[13] = ETH_TYPE_LO;
        end
        if (kind == FK_NON_IP) f[12] = 8'h08;
        if (kind == FK_VLAN) begin
            f[12] = 8'h81;
            f[13] = 8'h00;
        end
        if (kind inside {FK_RS, FK_NS, FK_DAD, FK_SHORT_NS} ||
            (kind == FK_SHORT_IP && len > 21 && $urandom_range(1))) begin
            f[20] = NH_ICMP6;
            f[21] = HOP_ND;
        end
        if (kind == FK_TUNNEL && len > 54 && $urandom_range(1)) begin
            // Near misses of the solicitation checks.
            f[20] = NH_ICMP6;
            f[21] = $urandom_range(1) ? HOP_ND : 8'd64;
            f[54] = $urandom_range(1) ? ICMP_NS : 8'd128;
        end
        if (kind == FK_RS) f[54] = ICMP_RS;
        if (kind == FK_NS || kind == FK_SHORT_NS || kind == FK_DAD) f[54] = ICMP_NS;
        if (kind == FK_DAD)
            for (int i = 22; i < 38; i++) f[i] = 8'h00;
        for (int i = 0; i < len; i++)
            send_byte(f[i], i == len - 1);
        frames_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_mac(logic [47:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return FK_NS;
        if (r < 55) return FK_TUNNEL;
        if (r < 62) return FK_RS;
        if (r < 68) return FK_DAD;
        if (r < 74) return FK_SHORT_NS;
        if (r < 80) return FK_SHORT_IP;
        if (r < 85) return FK_RUNT;
        if (r < 89) return FK_VLAN;
        if (r < 93) return FK_NON_IP;
        return FK_NOISE;
    endfunction

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A one-byte runt, an IPv6 frame with an empty payload, then a
        // solicitation with the reset MAC while the result side is held off.
        send_byte(8'hff, 1'b1);
        frames_sent++;
        for (int i = 0; i < 14; i++)
            send_byte(i == 12 ? ETH_TYPE_HI : i == 13 ? ETH_TYPE_LO : 8'h00, i == 13);
        frames_sent++;
        send_frame(FK_NS);
        push <= 1'b0;
        while (!hold_done) @(posedge clk);

        // A new MAC, a solicitation with no idling at all, then random frames.
        write_mac({$urandom, $urandom});
        steady = 1'b1;
        send_frame(FK_NS);
        steady = 1'b0;
        while (bytes_sent < 200)
            send_frame(pick_kind());
        drain();

        $display("Sent %0d frames (%0d bytes) under two router MAC values; %0d results checked.",
                 frames_sent, bytes_sent, results);
        if (errors == 0) begin
            $display("tb_ipv6_frame_classify_nd_responder_top: clean");
        end else begin
            $display("tb_ipv6_frame_classify_nd_responder_top: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results still expected.", pending);
        $display("tb_ipv6_frame_classify_nd_responder_top: errors");
        $finish;
    end

endmodule
